>>> design/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// Lattice fit package
// Shared widths, configuration register indexes and the scoring control
// group used across the lattice fit, score and assign pipeline.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int COEF_WIDTH_DEF     = 20;
    localparam int VEC_WIDTH_DEF      = 24;
    localparam int ERR_WIDTH_DEF      = 24;

    localparam int COEF_INT_BITS      = 8;
    localparam int VEC_INT_BITS       = 4;
    localparam int NUM_AXES           = 3;
    localparam int LABEL_WIDTH        = 16;
    localparam int ASSIGN_LABEL_WIDTH = 15;
    localparam int TOL_WIDTH          = 24;
    localparam int CFG_DATA_WIDTH     = 60;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int SQ_WIDTH           = 64;
    localparam int M32_WIDTH          = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MATRIX_ROW_0      = 3'd0,
        REG_MATRIX_ROW_1      = 3'd1,
        REG_MATRIX_ROW_2      = 3'd2,
        REG_TOLERANCE_SQUARED = 3'd3,
        REG_ASSIGN_LABEL      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [TOL_WIDTH-1:0]          tol_sq;
        logic [ASSIGN_LABEL_WIDTH-1:0] label;
    } score_cfg_t;

endpackage

>>> design/lfsa_in_if.sv
// ----------------------------------------------------------------------------
// Lattice fit input channel
// One beat carries a scattering vector with its current error and label.
// ----------------------------------------------------------------------------
interface lfsa_in_if
    import lfsa_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF,
    parameter int ERR_WIDTH = ERR_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VEC_WIDTH-1:0]   g_x;
    logic signed [VEC_WIDTH-1:0]   g_y;
    logic signed [VEC_WIDTH-1:0]   g_z;
    logic [ERR_WIDTH-1:0]          old_error;
    logic signed [LABEL_WIDTH-1:0] old_label;
    logic                          is_last;

    modport source (
        output valid, g_x, g_y, g_z, old_error, old_label, is_last,
        input  ready
    );

    modport sink (
        input  valid, g_x, g_y, g_z, old_error, old_label, is_last,
        output ready
    );
endinterface

>>> design/lfsa_out_if.sv
// ----------------------------------------------------------------------------
// Lattice fit result channel
// One beat carries the updated error, the updated label and the hit flag.
// ----------------------------------------------------------------------------
interface lfsa_out_if
    import lfsa_pkg::*;
#(
    parameter int ERR_WIDTH = ERR_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [ERR_WIDTH-1:0]          new_error;
    logic signed [LABEL_WIDTH-1:0] new_label;
    logic                          hit;
    logic                          last_out;

    modport source (
        output valid, new_error, new_label, hit, last_out,
        input  ready
    );

    modport sink (
        input  valid, new_error, new_label, hit, last_out,
        output ready
    );
endinterface

>>> design/lfsa_mat_mul.sv
// ----------------------------------------------------------------------------
// Lattice fit matrix product
// Two stages: nine coefficient by component products, then the row sums.
// Only the fractional bits of each row sum are kept.
// ----------------------------------------------------------------------------
module lfsa_mat_mul
    import lfsa_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
    parameter int SIDE_WIDTH = 1,
    localparam int FRAC_WIDTH = (COEF_WIDTH - COEF_INT_BITS) + (VEC_WIDTH - VEC_INT_BITS)
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [VEC_WIDTH-1:0]    g [NUM_AXES],
    input  logic [NUM_AXES*COEF_WIDTH-1:0] matrix [NUM_AXES],
    input  logic [SIDE_WIDTH-1:0]          side_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [FRAC_WIDTH-1:0]          frac [NUM_AXES],
    output logic [SIDE_WIDTH-1:0]          side_out
);

    localparam int PROD_WIDTH = COEF_WIDTH + VEC_WIDTH;

    logic signed [COEF_WIDTH-1:0] coef [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] prod_full [NUM_AXES][NUM_AXES];
    logic [FRAC_WIDTH-1:0]        prod_next [NUM_AXES][NUM_AXES];
    logic [FRAC_WIDTH-1:0]        prod_reg [NUM_AXES][NUM_AXES];
    logic [FRAC_WIDTH-1:0]        frac_next [NUM_AXES];
    logic [FRAC_WIDTH-1:0]        frac_reg [NUM_AXES];
    logic [SIDE_WIDTH-1:0]        a_side_reg;
    logic [SIDE_WIDTH-1:0]        b_side_reg;
    logic                         a_valid_reg;
    logic                         b_valid_reg;
    logic                         a_ready;
    logic                         b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                coef[r][c]      = matrix[r][c*COEF_WIDTH +: COEF_WIDTH];
                prod_full[r][c] = coef[r][c] * g[c];
                prod_next[r][c] = prod_full[r][c][FRAC_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            frac_next[r] = prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            prod_reg   <= prod_next;
            a_side_reg <= side_in;
        end
        if (a_valid_reg && b_ready)
        begin
            frac_reg   <= frac_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign frac      = frac_reg;
    assign side_out  = b_side_reg;

endmodule

>>> design/lfsa_residual.sv
// ----------------------------------------------------------------------------
// Lattice fit residual squares
// Two stages: distance of each row sum to the nearest integer brought to
// Q0.32, then its square as Q0.64.
// ----------------------------------------------------------------------------
module lfsa_residual
    import lfsa_pkg::*;
#(
    parameter int FRAC_WIDTH = 32,
    parameter int SIDE_WIDTH = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FRAC_WIDTH-1:0] frac [NUM_AXES],
    input  logic [SIDE_WIDTH-1:0] side_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SQ_WIDTH-1:0]   sq [NUM_AXES],
    output logic [SIDE_WIDTH-1:0] side_out
);

    localparam logic [FRAC_WIDTH-1:0] HALF    = {1'b1, {(FRAC_WIDTH-1){1'b0}}};
    localparam logic [M32_WIDTH-1:0]  M32_MAX = {1'b1, {(M32_WIDTH-1){1'b0}}};

    logic [FRAC_WIDTH-1:0] mag [NUM_AXES];
    logic [M32_WIDTH-1:0]  m32_next [NUM_AXES];
    logic [M32_WIDTH-1:0]  m32_reg [NUM_AXES];
    logic [SQ_WIDTH-1:0]   sq_next [NUM_AXES];
    logic [SQ_WIDTH-1:0]   sq_reg [NUM_AXES];
    logic [SIDE_WIDTH-1:0] c_side_reg;
    logic [SIDE_WIDTH-1:0] d_side_reg;
    logic                  c_valid_reg;
    logic                  d_valid_reg;
    logic                  c_ready;
    logic                  d_ready;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            mag[r] = (frac[r] <= HALF) ? frac[r] : (~frac[r] + 1'b1);
        end
    end

    generate
        if (FRAC_WIDTH > M32_WIDTH)
        begin : g_round
            localparam int DROP = FRAC_WIDTH - M32_WIDTH;
            logic [FRAC_WIDTH:0] rounded [NUM_AXES];
            logic [FRAC_WIDTH:0] shifted [NUM_AXES];

            always_comb
            begin
                for (int r = 0; r < NUM_AXES; r++)
                begin
                    rounded[r]  = {1'b0, mag[r]} + ((FRAC_WIDTH+1)'(1) << (DROP - 1));
                    shifted[r]  = rounded[r] >> DROP;
                    m32_next[r] = shifted[r][M32_WIDTH-1:0];
                end
            end
        end
        else
        begin : g_shift
            always_comb
            begin
                for (int r = 0; r < NUM_AXES; r++)
                begin
                    m32_next[r] = M32_WIDTH'(mag[r]) << (M32_WIDTH - FRAC_WIDTH);
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            sq_next[r] = SQ_WIDTH'(m32_reg[r]) * SQ_WIDTH'(m32_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && c_ready)
        begin
            m32_reg    <= m32_next;
            c_side_reg <= side_in;
        end
        if (c_valid_reg && d_ready)
        begin
            sq_reg     <= sq_next;
            d_side_reg <= c_side_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign sq        = sq_reg;
    assign side_out  = d_side_reg;

    // A residual is never more than one half, so its square is at most one quarter.
    a_m32_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (m32_reg[0] <= M32_MAX) && (m32_reg[1] <= M32_MAX)
                        && (m32_reg[2] <= M32_MAX))
        else $error("residual magnitude above one half");

endmodule

>>> design/lfsa_score.sv
// ----------------------------------------------------------------------------
// Lattice fit score and assign
// Sums and rounds the squared residuals, then decides the label update and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module lfsa_score
    import lfsa_pkg::*;
#(
    parameter int ERR_WIDTH  = ERR_WIDTH_DEF,
    parameter int SIDE_WIDTH = ERR_WIDTH_DEF + LABEL_WIDTH + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  score_cfg_t             cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SQ_WIDTH-1:0]    sq [NUM_AXES],
    input  logic [SIDE_WIDTH-1:0]  side_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ERR_WIDTH-1:0]   new_error,
    output logic [LABEL_WIDTH-1:0] new_label,
    output logic                   hit,
    output logic                   last_out
);

    localparam int SUM_WIDTH = SQ_WIDTH + 2;
    localparam int CMP_WIDTH = (ERR_WIDTH > TOL_WIDTH) ? ERR_WIDTH : TOL_WIDTH;
    localparam logic [SUM_WIDTH-1:0] ROUND_BIT = SUM_WIDTH'(1) << (SQ_WIDTH - 1 - ERR_WIDTH);
    localparam logic [CMP_WIDTH-1:0] ERR_MASK  = CMP_WIDTH'({ERR_WIDTH{1'b1}});
    localparam logic [ERR_WIDTH-1:0] S_MAX     = ERR_WIDTH'(3) << (ERR_WIDTH - 2);

    logic [SUM_WIDTH-1:0]   sum;
    logic [ERR_WIDTH+1:0]   s_wide;
    logic [ERR_WIDTH-1:0]   s_next;
    logic [ERR_WIDTH-1:0]   s_reg;
    logic [SIDE_WIDTH-1:0]  e_side_reg;
    logic [ERR_WIDTH-1:0]   old_error;
    logic [LABEL_WIDTH-1:0] old_label;
    logic                   is_last;
    logic [CMP_WIDTH-1:0]   tol_cmp;
    logic                   hit_next;
    logic [LABEL_WIDTH-1:0] label_next;
    logic [LABEL_WIDTH-1:0] cfg_label;
    logic [ERR_WIDTH-1:0]   error_next;
    logic [ERR_WIDTH-1:0]   new_error_reg;
    logic [LABEL_WIDTH-1:0] new_label_reg;
    logic                   hit_reg;
    logic                   last_reg;
    logic                   e_valid_reg;
    logic                   f_valid_reg;
    logic                   e_ready;
    logic                   f_ready;

    assign f_ready  = !f_valid_reg || out_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    always_comb
    begin
        sum    = SUM_WIDTH'(sq[0]) + SUM_WIDTH'(sq[1]) + SUM_WIDTH'(sq[2]) + ROUND_BIT;
        s_wide = sum[SUM_WIDTH-1:SQ_WIDTH-ERR_WIDTH];
        s_next = (|s_wide[ERR_WIDTH+1:ERR_WIDTH]) ? {ERR_WIDTH{1'b1}} : s_wide[ERR_WIDTH-1:0];
    end

    assign {old_error, old_label, is_last} = e_side_reg;
    assign tol_cmp   = CMP_WIDTH'(cfg.tol_sq) & ERR_MASK;
    assign cfg_label = {1'b0, cfg.label};

    always_comb
    begin
        hit_next   = (CMP_WIDTH'(s_reg) < tol_cmp) && (s_reg < old_error);
        error_next = hit_next ? s_reg : old_error;
        priority if (hit_next)
        begin
            label_next = cfg_label;
        end
        else if (old_label == cfg_label)
        begin
            label_next = {LABEL_WIDTH{1'b1}};
        end
        else
        begin
            label_next = old_label;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
            begin
                e_valid_reg <= in_valid;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && e_ready)
        begin
            s_reg      <= s_next;
            e_side_reg <= side_in;
        end
        if (e_valid_reg && f_ready)
        begin
            new_error_reg <= error_next;
            new_label_reg <= label_next;
            hit_reg       <= hit_next;
            last_reg      <= is_last;
        end
    end

    assign out_valid = f_valid_reg;
    assign new_error = new_error_reg;
    assign new_label = new_label_reg;
    assign hit       = hit_reg;
    assign last_out  = last_reg;

    // The sum of three squared residuals never exceeds three quarters.
    a_s_bound: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> s_reg <= S_MAX)
        else $error("rounded error above three quarters");

    // A hit always carries a non-negative label and an error below the old one.
    a_hit_label: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && f_ready && hit_next) |=> f_valid_reg && hit_reg
            && !new_label_reg[LABEL_WIDTH-1])
        else $error("hit without a valid label");

    a_hit_error: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && f_ready) |=> (new_error_reg == $past(error_next))
            && (hit_reg == $past(hit_next)))
        else $error("result register lost the decision");

endmodule

>>> design/lattice_fit_score_assign.sv
// ----------------------------------------------------------------------------
// Lattice fit, score and assign
// Six register stages: products, row sums, residuals, squares, error, result.
// A result leaves the result register after passing the stages in order; one beat a
// cycle is taken while the result side keeps up, each stage stalls alone.
// Reset clears all stage valid bits and sets every configuration register
// to zero.
// ----------------------------------------------------------------------------
module lattice_fit_score_assign
    import lfsa_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
    parameter int ERR_WIDTH  = ERR_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
    lfsa_in_if.sink                    item,
    lfsa_out_if.source                 result
);

    localparam int SIDE_WIDTH = ERR_WIDTH + LABEL_WIDTH + 1;
    localparam int FRAC_WIDTH = (COEF_WIDTH - COEF_INT_BITS) + (VEC_WIDTH - VEC_INT_BITS);
    localparam int ROW_WIDTH  = NUM_AXES * COEF_WIDTH;

    logic [ROW_WIDTH-1:0]          matrix_reg [NUM_AXES];
    logic [TOL_WIDTH-1:0]          tol_sq_reg;
    logic [ASSIGN_LABEL_WIDTH-1:0] label_reg;
    score_cfg_t                    score_cfg;

    logic signed [VEC_WIDTH-1:0]   g_vec [NUM_AXES];
    logic [SIDE_WIDTH-1:0]         side_in;
    logic [SIDE_WIDTH-1:0]         mm_side;
    logic [SIDE_WIDTH-1:0]         rs_side;
    logic [FRAC_WIDTH-1:0]         frac [NUM_AXES];
    logic [SQ_WIDTH-1:0]           sq [NUM_AXES];
    logic                          mm_valid;
    logic                          mm_ready;
    logic                          rs_valid;
    logic                          rs_ready;
    logic [LABEL_WIDTH-1:0]        new_label;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg[0] <= '0;
            matrix_reg[1] <= '0;
            matrix_reg[2] <= '0;
            tol_sq_reg    <= '0;
            label_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_MATRIX_ROW_0:      matrix_reg[0] <= wr_data[ROW_WIDTH-1:0];
                REG_MATRIX_ROW_1:      matrix_reg[1] <= wr_data[ROW_WIDTH-1:0];
                REG_MATRIX_ROW_2:      matrix_reg[2] <= wr_data[ROW_WIDTH-1:0];
                REG_TOLERANCE_SQUARED: tol_sq_reg    <= wr_data[TOL_WIDTH-1:0];
                REG_ASSIGN_LABEL:      label_reg     <= wr_data[ASSIGN_LABEL_WIDTH-1:0];
                default:               ;
            endcase
        end
    end

    assign score_cfg.tol_sq = tol_sq_reg;
    assign score_cfg.label  = label_reg;

    assign g_vec[0] = item.g_x;
    assign g_vec[1] = item.g_y;
    assign g_vec[2] = item.g_z;
    assign side_in  = {item.old_error, item.old_label, item.is_last};

    lfsa_mat_mul #(
        .COEF_WIDTH (COEF_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH),
        .SIDE_WIDTH (SIDE_WIDTH)
    ) u_mat_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .g         (g_vec),
        .matrix    (matrix_reg),
        .side_in   (side_in),
        .out_valid (mm_valid),
        .out_ready (mm_ready),
        .frac      (frac),
        .side_out  (mm_side)
    );

    lfsa_residual #(
        .FRAC_WIDTH (FRAC_WIDTH),
        .SIDE_WIDTH (SIDE_WIDTH)
    ) u_residual (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm_valid),
        .in_ready  (mm_ready),
        .frac      (frac),
        .side_in   (mm_side),
        .out_valid (rs_valid),
        .out_ready (rs_ready),
        .sq        (sq),
        .side_out  (rs_side)
    );

    lfsa_score #(
        .ERR_WIDTH  (ERR_WIDTH),
        .SIDE_WIDTH (SIDE_WIDTH)
    ) u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (score_cfg),
        .in_valid  (rs_valid),
        .in_ready  (rs_ready),
        .sq        (sq),
        .side_in   (rs_side),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .new_error (result.new_error),
        .new_label (new_label),
        .hit       (result.hit),
        .last_out  (result.last_out)
    );

    assign result.new_label = new_label;

endmodule
